// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin thread scheduler.
package rrts_pkg;

    // Default number of thread slots.
    localparam int THREAD_COUNT_DEF = 8;

    // Field widths fixed by the stream format.
    localparam int OP_W     = 2;
    localparam int THREAD_W = 3;
    localparam int STATUS_W = 2;

    // Per-slot thread state.
    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_READY = 2'd1,
        SLOT_RUN   = 2'd2,
        SLOT_DONE  = 2'd3
    } slot_state_t;

    // Event kinds.
    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_YIELD  = 2'd1,
        OP_EXIT   = 2'd2,
        OP_JOIN   = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE         = 2'd0,
        ST_NO_FREE_SLOT = 2'd1,
        ST_BAD_TARGET   = 2'd2,
        ST_NOT_FINISHED = 2'd3
    } status_t;

    // One result item.
    typedef struct packed {
        logic                switched;
        logic [THREAD_W-1:0] running_thread;
        logic [THREAD_W-1:0] created_thread;
        status_t             status;
    } result_t;

endpackage

// ===== hw/rtl/rrts_event_logic.sv =====
// Combinational event evaluation: next slot table, next running slot and result.
module rrts_event_logic #(
    parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF,
    localparam int SlotW = $clog2(THREAD_COUNT)
) (
    input  rrts_pkg::slot_state_t            slot_state [THREAD_COUNT],
    input  logic [SlotW-1:0]                 current_slot,
    input  rrts_pkg::op_t                    operation,
    input  logic [rrts_pkg::THREAD_W-1:0]    target_thread,
    output rrts_pkg::slot_state_t            slot_state_next [THREAD_COUNT],
    output logic [SlotW-1:0]                 current_slot_next,
    output rrts_pkg::result_t                result
);

    rrts_pkg::slot_state_t mid_state   [THREAD_COUNT];
    rrts_pkg::slot_state_t yield_state [THREAD_COUNT];
    logic [THREAD_COUNT-1:0] ready_vec;
    logic [THREAD_COUNT-1:0] free_vec;
    logic [THREAD_COUNT-1:0] above_vec;
    logic [SlotW-1:0]        pick_hi;
    logic [SlotW-1:0]        pick_any;
    logic                    found_hi;
    logic                    found_any;
    logic [SlotW-1:0]        yield_slot;
    logic                    yield_found;
    logic [SlotW-1:0]        yield_cur;
    logic [SlotW-1:0]        free_slot;
    logic                    free_found;
    logic                    target_ok;
    logic [SlotW+rrts_pkg::THREAD_W-1:0] target_ext;
    logic [SlotW-1:0]        target_idx;
    logic [SlotW+rrts_pkg::THREAD_W-1:0] created_ext;
    logic [SlotW+rrts_pkg::THREAD_W-1:0] running_ext;
    logic [SlotW-1:0]        created_slot;
    rrts_pkg::status_t       status_sel;

    // Exit marks the current slot finished before the yield scan.
    always_comb
    begin
        for (int i = 0; i < THREAD_COUNT; i++)
        begin
            mid_state[i] = slot_state[i];
        end
        if (operation == rrts_pkg::OP_EXIT)
        begin
            mid_state[current_slot] = rrts_pkg::SLOT_DONE;
        end
    end

    // Candidate vectors for the yield scan and the free-slot search.
    always_comb
    begin
        for (int i = 0; i < THREAD_COUNT; i++)
        begin
            ready_vec[i] = (mid_state[i] == rrts_pkg::SLOT_READY);
            free_vec[i]  = (slot_state[i] == rrts_pkg::SLOT_FREE) && (i != 0);
            above_vec[i] = (i > int'(current_slot));
        end
    end

    // Rotating priority pick: first ready slot above the current one,
    // otherwise the lowest ready slot, which covers the wrap back to current.
    always_comb
    begin
        pick_hi   = '0;
        found_hi  = 1'b0;
        pick_any  = '0;
        found_any = 1'b0;
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = THREAD_COUNT - 1; i >= 0; i--)
        begin
            if (ready_vec[i] && above_vec[i])
            begin
                pick_hi  = SlotW'(i);
                found_hi = 1'b1;
            end
            if (ready_vec[i])
            begin
                pick_any  = SlotW'(i);
                found_any = 1'b1;
            end
            if (free_vec[i])
            begin
                free_slot  = SlotW'(i);
                free_found = 1'b1;
            end
        end
        yield_slot  = found_hi ? pick_hi : pick_any;
        yield_found = found_any;
    end

    // Slot table after a yield.
    always_comb
    begin
        for (int i = 0; i < THREAD_COUNT; i++)
        begin
            yield_state[i] = mid_state[i];
        end
        yield_cur = current_slot;
        if (yield_found)
        begin
            if (mid_state[current_slot] == rrts_pkg::SLOT_RUN)
            begin
                yield_state[current_slot] = rrts_pkg::SLOT_READY;
            end
            yield_state[yield_slot] = rrts_pkg::SLOT_RUN;
            yield_cur = yield_slot;
        end
    end

    // Join target range check and slot index.
    assign target_ok  = (target_thread != '0) && (32'(target_thread) < THREAD_COUNT);
    assign target_ext = {{SlotW{1'b0}}, target_thread};
    assign target_idx = target_ext[SlotW-1:0];

    // Per-event selection of the next state and the status.
    always_comb
    begin
        for (int i = 0; i < THREAD_COUNT; i++)
        begin
            slot_state_next[i] = slot_state[i];
        end
        current_slot_next = current_slot;
        created_slot      = '0;
        status_sel        = rrts_pkg::ST_DONE;
        case (operation)
            rrts_pkg::OP_CREATE:
            begin
                if (free_found)
                begin
                    slot_state_next[free_slot] = rrts_pkg::SLOT_READY;
                    created_slot = free_slot;
                end
                else
                begin
                    status_sel = rrts_pkg::ST_NO_FREE_SLOT;
                end
            end
            rrts_pkg::OP_YIELD, rrts_pkg::OP_EXIT:
            begin
                for (int i = 0; i < THREAD_COUNT; i++)
                begin
                    slot_state_next[i] = yield_state[i];
                end
                current_slot_next = yield_cur;
            end
            rrts_pkg::OP_JOIN:
            begin
                if (!target_ok)
                begin
                    status_sel = rrts_pkg::ST_BAD_TARGET;
                end
                else if (slot_state[target_idx] == rrts_pkg::SLOT_DONE)
                begin
                    slot_state_next[target_idx] = rrts_pkg::SLOT_FREE;
                end
                else
                begin
                    for (int i = 0; i < THREAD_COUNT; i++)
                    begin
                        slot_state_next[i] = yield_state[i];
                    end
                    current_slot_next = yield_cur;
                    status_sel        = rrts_pkg::ST_NOT_FINISHED;
                end
            end
            default:
            begin
                status_sel = rrts_pkg::ST_DONE;
            end
        endcase
    end

    // Result fields carry the low bits of the slot numbers.
    assign created_ext = {{rrts_pkg::THREAD_W{1'b0}}, created_slot};
    assign running_ext = {{rrts_pkg::THREAD_W{1'b0}}, current_slot_next};
    assign result      = {(current_slot_next != current_slot),
                          running_ext[rrts_pkg::THREAD_W-1:0],
                          created_ext[rrts_pkg::THREAD_W-1:0],
                          status_sel};

endmodule

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
// Round-robin thread scheduler top level: input register, slot table, result register.
// The input register holds each event until it advances; the result register and the slot table
// then load together, and the advance stalls while the result register is full and m_tready is low.
// Throughput: one event per cycle while the output drains, set by the single-pass rotating pick.
// Reset (rst_n low, asynchronous): slot 0 running, all other slots free, running slot 0,
// both pipeline registers empty.
module round_robin_thread_scheduler #(
    parameter int THREAD_COUNT = rrts_pkg::THREAD_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] operation, [4:2] target_thread, [7:5] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [4:2] created_thread,
                                   // [7:5] running_thread, [8] switched, [15:9] zero
);

    localparam int SlotW = $clog2(THREAD_COUNT);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    rrts_pkg::op_t                      op_reg;
    logic [rrts_pkg::THREAD_W-1:0]      target_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    rrts_pkg::result_t                  out_reg;
    rrts_pkg::slot_state_t              slot_state_reg  [THREAD_COUNT];
    rrts_pkg::slot_state_t              slot_state_next [THREAD_COUNT];
    logic [SlotW-1:0]                   current_slot_reg;
    logic [SlotW-1:0]                   current_slot_next;
    rrts_pkg::result_t                  result;
    logic                               in_xfer;
    logic                               advance;
    logic [THREAD_COUNT-1:0]            run_vec;
    logic [THREAD_COUNT-1:0]            cur_onehot;

    // Handshake: the item moves on when the result register is empty or drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    assign in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : ((m_tready) ? 1'b0 : out_valid_reg);

    // Event evaluation against the current slot table.
    rrts_event_logic #(
        .THREAD_COUNT(THREAD_COUNT)
    ) u_event_logic (
        .slot_state        (slot_state_reg),
        .current_slot      (current_slot_reg),
        .operation         (op_reg),
        .target_thread     (target_reg),
        .slot_state_next   (slot_state_next),
        .current_slot_next (current_slot_next),
        .result            (result)
    );

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg     <= rrts_pkg::op_t'(s_tdata[1:0]);
            target_reg <= s_tdata[4:2];
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    // Slot table and running slot, updated as each event retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_COUNT; i++)
            begin
                slot_state_reg[i] <= (i == 0) ? rrts_pkg::SLOT_RUN : rrts_pkg::SLOT_FREE;
            end
            current_slot_reg <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < THREAD_COUNT; i++)
            begin
                slot_state_reg[i] <= slot_state_next[i];
            end
            current_slot_reg <= current_slot_next;
        end
    end

    // Output packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.switched, out_reg.running_thread,
                       out_reg.created_thread, out_reg.status};

    // Running-slot bookkeeping for the checks below.
    always_comb
    begin
        for (int i = 0; i < THREAD_COUNT; i++)
        begin
            run_vec[i]    = (slot_state_reg[i] == rrts_pkg::SLOT_RUN);
            cur_onehot[i] = (i == int'(current_slot_reg));
        end
    end

    // At most one slot is running, and only the current one.
    a_single_runner: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(run_vec) <= 1) && ((run_vec & ~cur_onehot) == '0))
        else $error("running slot is not unique or not current");

    // A retiring event always lands in the result register.
    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost on advance");

    // A switch happens only on yield-type outcomes.
    a_switch_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.switched) |->
        (out_reg.status == rrts_pkg::ST_DONE || out_reg.status == rrts_pkg::ST_NOT_FINISHED))
        else $error("switch reported with a failing status");

    // A nonzero created slot comes only with a done status and never with a switch.
    a_create_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.created_thread != '0) |->
        (out_reg.status == rrts_pkg::ST_DONE && !out_reg.switched))
        else $error("inconsistent create result");

    // The switched flag follows the change of the running slot.
    a_running_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.switched == (current_slot_reg != $past(current_slot_reg))))
        else $error("switched flag disagrees with running slot");

endmodule
